// ===== sv/bcwc_pkg.sv =====
// types and constants shared by the box-crop windowed centroid block
// no dependencies
`timescale 1ns / 1ps

package bcwc_pkg;

	localparam int COORD_BITS   = 20;
	localparam int COUNT_BITS   = 24;
	localparam int SUM_BITS     = COORD_BITS + COUNT_BITS;
	localparam int WIN_BITS     = 8;
	localparam int CFG_IDX_BITS = 3;
	localparam int STEP_BITS    = $clog2(SUM_BITS);
	localparam int Q_DEPTH      = 2;
	localparam int Q_PTR_BITS   = 1;

	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_X_LOW     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_X_HIGH    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Y_LOW     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Y_HIGH    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Z_LOW     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Z_HIGH    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_FRAMES = 3'd6;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] point_z;
		logic                         point_valid;
		logic                         frame_start;
		logic                         frame_end;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] centroid_x;
		logic signed [COORD_BITS-1:0] centroid_y;
		logic signed [COORD_BITS-1:0] centroid_z;
		logic [COUNT_BITS-1:0]        held_points;
		logic                         window_empty;
		logic                         count_overflow;
	} out_item_t;

	// held window snapshot handed from the front end to the divider
	typedef struct packed {
		logic signed [SUM_BITS-1:0] sum_x;
		logic signed [SUM_BITS-1:0] sum_y;
		logic signed [SUM_BITS-1:0] sum_z;
		logic [COUNT_BITS-1:0]      count;
		logic                       overflow;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_FIN
	} bk_state_t;

endpackage

// ===== sv/bcwc_front.sv =====
// front end: config registers, box test, running and held window sums
// depends on bcwc_pkg
`timescale 1ns / 1ps

module bcwc_front #(
	parameter int FRAC_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  bcwc_pkg::in_item_t               in_data,
	input  logic                             cfg_we,
	input  logic [bcwc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [bcwc_pkg::COORD_BITS-1:0]  cfg_data,
	output bcwc_pkg::job_t                   job,
	output logic                             job_push,
	input  logic                             job_full
);
	import bcwc_pkg::*;

	localparam int BND_BITS = (COORD_BITS > FRAC_BITS + 6) ? COORD_BITS : FRAC_BITS + 6;

	localparam logic signed [BND_BITS-1:0] XLO_RST = BND_BITS'(17) << FRAC_BITS;
	localparam logic signed [BND_BITS-1:0] XHI_RST = BND_BITS'(23) << FRAC_BITS;
	localparam logic signed [BND_BITS-1:0] YLO_RST = -(BND_BITS'(23) << FRAC_BITS);
	localparam logic signed [BND_BITS-1:0] YHI_RST = -(BND_BITS'(17) << FRAC_BITS);
	localparam logic signed [BND_BITS-1:0] ZLO_RST = (BND_BITS'(1) << FRAC_BITS) >> 1;
	localparam logic signed [BND_BITS-1:0] ZHI_RST = BND_BITS'(4) << FRAC_BITS;

	logic signed [BND_BITS-1:0] xlo_q, xhi_q, ylo_q, yhi_q, zlo_q, zhi_q;
	logic [WIN_BITS-1:0]        win_q;
	logic [WIN_BITS-1:0]        fiw_q;

	logic signed [SUM_BITS-1:0] run_x_q, run_y_q, run_z_q;
	logic [COUNT_BITS-1:0]      run_cnt_q;
	logic                       run_ovf_q;
	logic signed [SUM_BITS-1:0] held_x_q, held_y_q, held_z_q;
	logic [COUNT_BITS-1:0]      held_cnt_q;
	logic                       held_ovf_q;

	logic signed [BND_BITS-1:0] px, py, pz;
	logic                       hit;
	logic                       accept;
	logic [WIN_BITS-1:0]        limit;
	logic [WIN_BITS:0]          fiw_next;
	logic                       handover;
	logic signed [SUM_BITS-1:0] base_x, base_y, base_z;
	logic [COUNT_BITS-1:0]      base_cnt;
	logic                       base_ovf;
	logic                       sat;
	logic signed [SUM_BITS-1:0] cfg_ext;

	assign in_ready = !job_full;
	assign accept   = in_valid && in_ready;
	assign cfg_ext  = SUM_BITS'($signed(cfg_data));

	assign px = BND_BITS'($signed(in_data.point_x));
	assign py = BND_BITS'($signed(in_data.point_y));
	assign pz = BND_BITS'($signed(in_data.point_z));

	assign hit = in_data.point_valid
		&& (px > xlo_q) && (px < xhi_q)
		&& (py > ylo_q) && (py < yhi_q)
		&& (pz > zlo_q) && (pz < zhi_q);

	assign limit    = (win_q == '0) ? WIN_BITS'(1) : win_q;
	assign fiw_next = {1'b0, fiw_q} + (WIN_BITS+1)'(1);
	assign handover = in_data.frame_start && (fiw_next >= {1'b0, limit});

	assign base_x   = handover ? '0 : run_x_q;
	assign base_y   = handover ? '0 : run_y_q;
	assign base_z   = handover ? '0 : run_z_q;
	assign base_cnt = handover ? '0 : run_cnt_q;
	assign base_ovf = handover ? 1'b0 : run_ovf_q;
	assign sat      = &base_cnt;

	// result of a frame end sees the held window after this item's handover
	assign job_push = accept && in_data.frame_end;
	always_comb begin
		if (handover) begin
			job.sum_x    = run_x_q;
			job.sum_y    = run_y_q;
			job.sum_z    = run_z_q;
			job.count    = run_cnt_q;
			job.overflow = run_ovf_q;
		end else begin
			job.sum_x    = held_x_q;
			job.sum_y    = held_y_q;
			job.sum_z    = held_z_q;
			job.count    = held_cnt_q;
			job.overflow = held_ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xlo_q <= XLO_RST;
			xhi_q <= XHI_RST;
			ylo_q <= YLO_RST;
			yhi_q <= YHI_RST;
			zlo_q <= ZLO_RST;
			zhi_q <= ZHI_RST;
			win_q <= WIN_BITS'(6);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BOX_X_LOW:     xlo_q <= BND_BITS'(cfg_ext);
				REG_BOX_X_HIGH:    xhi_q <= BND_BITS'(cfg_ext);
				REG_BOX_Y_LOW:     ylo_q <= BND_BITS'(cfg_ext);
				REG_BOX_Y_HIGH:    yhi_q <= BND_BITS'(cfg_ext);
				REG_BOX_Z_LOW:     zlo_q <= BND_BITS'(cfg_ext);
				REG_BOX_Z_HIGH:    zhi_q <= BND_BITS'(cfg_ext);
				REG_WINDOW_FRAMES: win_q <= cfg_data[WIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiw_q      <= '0;
			run_x_q    <= '0;
			run_y_q    <= '0;
			run_z_q    <= '0;
			run_cnt_q  <= '0;
			run_ovf_q  <= 1'b0;
			held_x_q   <= '0;
			held_y_q   <= '0;
			held_z_q   <= '0;
			held_cnt_q <= '0;
			held_ovf_q <= 1'b0;
		end else if (accept) begin
			if (handover) begin
				held_x_q   <= run_x_q;
				held_y_q   <= run_y_q;
				held_z_q   <= run_z_q;
				held_cnt_q <= run_cnt_q;
				held_ovf_q <= run_ovf_q;
				fiw_q      <= '0;
			end else if (in_data.frame_start) begin
				fiw_q <= fiw_next[WIN_BITS-1:0];
			end
			if (hit && !sat) begin
				run_x_q   <= base_x + SUM_BITS'($signed(in_data.point_x));
				run_y_q   <= base_y + SUM_BITS'($signed(in_data.point_y));
				run_z_q   <= base_z + SUM_BITS'($signed(in_data.point_z));
				run_cnt_q <= base_cnt + COUNT_BITS'(1);
				run_ovf_q <= base_ovf;
			end else begin
				run_x_q   <= base_x;
				run_y_q   <= base_y;
				run_z_q   <= base_z;
				run_cnt_q <= base_cnt;
				run_ovf_q <= base_ovf || (hit && sat);
			end
		end
	end

endmodule

// ===== sv/bcwc_queue.sv =====
// two-slot queue of held window snapshots between front end and divider
// depends on bcwc_pkg
`timescale 1ns / 1ps

module bcwc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  bcwc_pkg::job_t wr_job,
	input  logic           push,
	output bcwc_pkg::job_t rd_job,
	input  logic           pop,
	output logic           full,
	output logic           empty
);
	import bcwc_pkg::*;

	job_t                  slot_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_PTR_BITS:0]   fill_q;
	logic                  do_push, do_pop;

	assign full  = (fill_q == (Q_PTR_BITS+1)'(Q_DEPTH));
	assign empty = (fill_q == '0);

	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_job  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_BITS'(1);
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + (Q_PTR_BITS+1)'(1);
				2'b01:   fill_q <= fill_q - (Q_PTR_BITS+1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== sv/bcwc_div.sv =====
// back end: bit-serial divide of the three held sums by the count, result register
// depends on bcwc_pkg
`timescale 1ns / 1ps

module bcwc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  bcwc_pkg::job_t      job,
	input  logic                job_valid,
	output logic                job_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output bcwc_pkg::out_item_t out_data
);
	import bcwc_pkg::*;

	bk_state_t state_q, state_d;

	logic [SUM_BITS-1:0]   quo_q [3];
	logic [COUNT_BITS-1:0] rem_q [3];
	logic                  neg_q [3];
	logic [COUNT_BITS-1:0] div_q;
	logic                  ovf_q;
	logic                  empty_q;
	logic [STEP_BITS-1:0]  step_q;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic                  load, out_load;
	logic [COUNT_BITS:0]   trial [3];
	logic                  ge [3];
	logic [SUM_BITS-1:0]   sum_in [3];
	logic [COORD_BITS-1:0] res [3];

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sum_in[0] = job.sum_x;
	assign sum_in[1] = job.sum_y;
	assign sum_in[2] = job.sum_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			trial[i] = {rem_q[i], quo_q[i][SUM_BITS-1]};
			ge[i]    = trial[i] >= {1'b0, div_q};
			res[i]   = neg_q[i] ? -quo_q[i][COORD_BITS-1:0] : quo_q[i][COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		load     = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					load    = 1'b1;
					state_d = (job.count == '0) ? BK_FIN : BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == '0) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// divider lanes, restoring, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < 3; i++) begin
				neg_q[i] <= sum_in[i][SUM_BITS-1];
				quo_q[i] <= sum_in[i][SUM_BITS-1] ? -sum_in[i] : sum_in[i];
				rem_q[i] <= '0;
			end
			div_q   <= job.count;
			ovf_q   <= job.overflow;
			empty_q <= (job.count == '0);
			step_q  <= STEP_BITS'(SUM_BITS - 1);
		end else if (state_q == BK_DIV) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= ge[i] ? COUNT_BITS'(trial[i] - {1'b0, div_q})
				                  : trial[i][COUNT_BITS-1:0];
				quo_q[i] <= {quo_q[i][SUM_BITS-2:0], ge[i]};
			end
			step_q <= step_q - STEP_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.centroid_x     <= empty_q ? '0 : res[0];
			out_q.centroid_y     <= empty_q ? '0 : res[1];
			out_q.centroid_z     <= empty_q ? '0 : res[2];
			out_q.held_points    <= div_q;
			out_q.window_empty   <= empty_q;
			out_q.count_overflow <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/box_crop_windowed_centroid_unit.sv =====
// top level of the box-crop windowed centroid block
// depends on bcwc_pkg, bcwc_front, bcwc_queue, bcwc_div
//
//   channel  signals                      transfer when
//   in       in_valid in_ready in_data    in_valid && in_ready
//   out      out_valid out_ready out_data out_valid && out_ready
//   cfg      cfg_we cfg_index cfg_data    cfg_we
//
// points are taken one per cycle unless stalled, gathered in the cycle of their transfer
// each frame end pushes a held window snapshot into a two-entry queue
// the divider works out a result bit by bit; an empty window skips the division
// in_ready drops only while the queue is full, so frame ends that outpace the divider
// will stall the input; the result register lets the divider start the next job
// reset clears front end sums, counters and flags; box and window registers get defaults
`timescale 1ns / 1ps

module box_crop_windowed_centroid_unit #(
	parameter int FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  bcwc_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output bcwc_pkg::out_item_t               out_data,
	input  logic                              cfg_we,
	input  logic [bcwc_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [bcwc_pkg::COORD_BITS-1:0]   cfg_data
);
	import bcwc_pkg::*;

	job_t push_job, head_job;
	logic job_push, job_pop;
	logic q_full, q_empty;

	bcwc_front #(
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.job      (push_job),
		.job_push (job_push),
		.job_full (q_full)
	);

	bcwc_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_job(push_job),
		.push  (job_push),
		.rd_job(head_job),
		.pop   (job_pop),
		.full  (q_full),
		.empty (q_empty)
	);

	bcwc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (head_job),
		.job_valid(!q_empty),
		.job_pop  (job_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
